>>> rtl/core/bdks_pkg.sv
// Shared types, constants and the volume map for the button debounce and knob smoother.
// No dependencies; every other file in rtl/core imports this package.
package bdks_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned KNOB_W      = 12;
    localparam int unsigned VOL_W       = 5;
    localparam int unsigned AVG_FRAC    = 8;
    localparam int unsigned AVG_SHIFT   = 3;
    localparam int unsigned AVG_W       = KNOB_W + AVG_FRAC;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] QUIET_RESET    = 16'd50;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd20;

    // x*21/4095 equals x/195; the reciprocal below is exact for every 12-bit x
    localparam int unsigned      VOL_RECIP_W     = 13;
    localparam int unsigned      VOL_RECIP_SHIFT = 20;
    localparam logic [VOL_RECIP_W-1:0] VOL_RECIP = 13'd5378;

    typedef enum logic {
        REG_DEBOUNCE_QUIET = 1'b0,
        REG_KNOB_INTERVAL  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_level;
        logic [KNOB_W-1:0] knob_sample;
        logic              take_press;
    } in_item_t;

    typedef struct packed {
        logic             press_seen;
        logic             stable_button;
        logic [VOL_W-1:0] volume;
    } out_item_t;

    typedef struct packed {
        logic stable_button;
        logic press_seen;
    } dbc_status_t;

    function automatic logic [VOL_W-1:0] volume_of(input logic [KNOB_W-1:0] whole);
        logic [KNOB_W+VOL_RECIP_W-1:0] product;
        product = {{VOL_RECIP_W{1'b0}}, whole} * {{KNOB_W{1'b0}}, VOL_RECIP};
        return product[VOL_RECIP_SHIFT +: VOL_W];
    endfunction

endpackage

>>> rtl/core/bdks_debounce.sv
// Button debouncer with press latch; one polling step per advance strobe.
// Depends on bdks_pkg.
module bdks_debounce (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [bdks_pkg::TIME_W-1:0]   now_ms,
    input  logic                          button_level,
    input  logic                          take_press,
    input  logic [bdks_pkg::CFG_W-1:0]    quiet_ms,
    output bdks_pkg::dbc_status_t         status
);
    import bdks_pkg::*;

    logic              prev_level_reg;
    logic              debounced_reg, debounced_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic              press_reg, press_next;
    logic [TIME_W-1:0] elapsed;
    logic              settle;
    logic              latched_mid;

    always_comb begin
        change_time_next = (button_level != prev_level_reg) ? now_ms : change_time_reg;
        elapsed          = now_ms - change_time_next;
        settle           = (elapsed > {{(TIME_W-CFG_W){1'b0}}, quiet_ms})
                           && (button_level != debounced_reg);
        debounced_next   = settle ? button_level : debounced_reg;
        // a settle to the pressed level latches a press
        latched_mid      = press_reg | (settle & ~button_level);
        press_next       = take_press ? 1'b0 : latched_mid;
        status.stable_button = debounced_next;
        status.press_seen    = take_press & latched_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg  <= 1'b1;
            debounced_reg   <= 1'b1;
            change_time_reg <= '0;
            press_reg       <= 1'b0;
        end else if (advance) begin
            prev_level_reg  <= button_level;
            debounced_reg   <= debounced_next;
            change_time_reg <= change_time_next;
            press_reg       <= press_next;
        end
    end

endmodule

>>> rtl/core/bdks_knob.sv
// Knob smoother: interval-gated 1/8 exponential average and volume map.
// Depends on bdks_pkg.
module bdks_knob (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [bdks_pkg::TIME_W-1:0]   now_ms,
    input  logic [bdks_pkg::KNOB_W-1:0]   knob_sample,
    input  logic [bdks_pkg::CFG_W-1:0]    interval_ms,
    output logic [bdks_pkg::VOL_W-1:0]    volume
);
    import bdks_pkg::*;

    logic [TIME_W-1:0] sample_time_reg;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic              loaded_reg;
    logic [VOL_W-1:0]  volume_reg, volume_next;
    logic [TIME_W-1:0] since;
    logic              due;
    logic [AVG_W-1:0]  blended;

    always_comb begin
        since   = now_ms - sample_time_reg;
        due     = since >= {{(TIME_W-CFG_W){1'b0}}, interval_ms};
        blended = avg_reg - (avg_reg >> AVG_SHIFT)
                + {{(AVG_SHIFT){1'b0}}, knob_sample, {(AVG_FRAC-AVG_SHIFT){1'b0}}};
        avg_next    = loaded_reg ? blended : {knob_sample, {AVG_FRAC{1'b0}}};
        volume_next = due ? volume_of(avg_next[AVG_W-1 -: KNOB_W]) : volume_reg;
        volume      = volume_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_time_reg <= '0;
            avg_reg         <= '0;
            loaded_reg      <= 1'b0;
            volume_reg      <= '0;
        end else if (advance && due) begin
            sample_time_reg <= now_ms;
            avg_reg         <= avg_next;
            loaded_reg      <= 1'b1;
            volume_reg      <= volume_next;
        end
    end

endmodule

>>> rtl/core/button_debounce_and_knob_smoother_top.sv
// Top level of the button debouncer and knob smoother: APB registers, request pipeline.
// Depends on bdks_pkg, bdks_debounce and bdks_knob.
//
// Each request is one polling step (time stamp, raw active-low button level, knob
// sample, take-press bit) and yields exactly one result (press seen, debounced level,
// volume 0..21). The block takes one request per clock unless the result side stalls;
// a request passes through an input register and then a result register, from which
// its result is taken. The debounce and knob units run between those two registers
// and update their state once per request, so a new request can enter while the
// previous one is still in the pipeline. The quiet time and sample interval live in
// APB registers at byte addresses 0 and 4 (16 bits each, reset 50 and 20 ms); write
// them only while no request is in flight.
module button_debounce_and_knob_smoother_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdks_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bdks_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bdks_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bdks_pkg::in_item_t                s_item,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output bdks_pkg::out_item_t               m_item
);
    import bdks_pkg::*;

    logic [CFG_W-1:0] quiet_reg;
    logic [CFG_W-1:0] interval_reg;
    cfg_reg_t         reg_sel;

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             out_free;
    logic             advance;
    dbc_status_t      dbc_status;
    logic [VOL_W-1:0] knob_volume;

    // ---- configuration registers ----
    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            REG_DEBOUNCE_QUIET: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, quiet_reg};
            REG_KNOB_INTERVAL:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, interval_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_reg    <= QUIET_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (psel && penable && pwrite) begin
            // keep the low half-word; upper bits of the write are dropped
            unique case (reg_sel)
                REG_DEBOUNCE_QUIET: quiet_reg    <= pwdata[CFG_W-1:0];
                REG_KNOB_INTERVAL:  interval_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- request pipeline ----
    // The result register frees up whenever it is empty or being taken; the input
    // register then hands its request on, and a new request may enter behind it.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // hold the payload; it is only looked at while valid
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // ---- step units: state advances once per request leaving the input register ----
    bdks_debounce u_debounce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .now_ms       (in_item_reg.now_ms),
        .button_level (in_item_reg.button_level),
        .take_press   (in_item_reg.take_press),
        .quiet_ms     (quiet_reg),
        .status       (dbc_status)
    );

    bdks_knob u_knob (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .now_ms      (in_item_reg.now_ms),
        .knob_sample (in_item_reg.knob_sample),
        .interval_ms (interval_reg),
        .volume      (knob_volume)
    );

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg.press_seen    <= dbc_status.press_seen;
            out_item_reg.stable_button <= dbc_status.stable_button;
            out_item_reg.volume        <= knob_volume;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

>>> rtl/core/bdks_checker.sv
// Port-level checks for the button debounce and knob smoother top level, plus its bind.
// Depends on bdks_pkg and button_debounce_and_knob_smoother_top.
module bdks_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bdks_pkg::out_item_t m_item
);
    import bdks_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // nothing comes out right after a reset cycle
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty result side never blocks requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with empty result register");

    // volume stays on its scale
    a_volume_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.volume <= 5'd21)
        else $error("volume beyond 21");

endmodule

bind button_debounce_and_knob_smoother_top bdks_checker u_bdks_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for button_debounce_and_knob_smoother_top: directed poll steps, then
// randomized press/bounce episodes under several register settings. Prediction runs in-bench.
// Depends on bdks_pkg and the RTL under rtl/core.
module tb_top;
    import bdks_pkg::*;

    localparam int unsigned HALF_PERIOD   = 10;
    localparam int unsigned KNOB_FULL     = 4095;
    localparam int unsigned VOLUME_TOP    = 21;
    localparam int unsigned PHASE_POLLS   = 90;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned HOLD_SPACING  = 150;
    localparam int unsigned STALL_LIMIT   = 1000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_THREE_OF_FOUR,
        READY_COIN,
        READY_ONE_OF_THREE
    } ready_mode_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    in_item_t              s_item   = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    out_item_t             m_item;

    button_debounce_and_knob_smoother_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench copy of the block: register values and debounce/smoothing state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  quiet_ms       = QUIET_RESET;
    logic [CFG_W-1:0]  interval_ms    = INTERVAL_RESET;
    logic              raw_prev       = 1'b1;
    logic              stable_level   = 1'b1;
    logic [TIME_W-1:0] last_change_ms = '0;
    logic              press_flag     = 1'b0;
    logic [TIME_W-1:0] last_sample_ms = '0;
    logic [AVG_W-1:0]  avg_fix        = '0;
    logic              avg_valid      = 1'b0;
    logic [VOL_W-1:0]  vol_now        = '0;

    in_item_t  poll_steps[$];    // requests waiting for the driver
    out_item_t results_due[$];   // predicted results, oldest first
    int unsigned mismatches    = 0;
    int unsigned results_taken = 0;

    // Advance the bench state by one poll step and return the result it must produce.
    function automatic out_item_t debounce_and_smooth(input in_item_t req);
        out_item_t         res;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_sample;
        logic [31:0]       acc;
        int unsigned       whole;
        res = '0;
        // any raw edge restarts the quiet timer; accept only after strictly more than quiet
        if (req.button_level != raw_prev)
            last_change_ms = req.now_ms;
        since_change = req.now_ms - last_change_ms;
        if (since_change > {16'b0, quiet_ms} && req.button_level != stable_level) begin
            stable_level = req.button_level;
            if (!req.button_level)
                press_flag = 1'b1;
        end
        raw_prev = req.button_level;
        // fold the knob in once the interval has elapsed (modulo time, so wrap is fine)
        since_sample = req.now_ms - last_sample_ms;
        if (since_sample >= {16'b0, interval_ms}) begin
            last_sample_ms = req.now_ms;
            if (!avg_valid) begin
                acc       = {20'b0, req.knob_sample} << AVG_FRAC;
                avg_valid = 1'b1;
            end else begin
                acc = {12'b0, avg_fix} - ({12'b0, avg_fix} >> AVG_SHIFT)
                    + ({20'b0, req.knob_sample} << (AVG_FRAC - AVG_SHIFT));
            end
            avg_fix = acc[AVG_W-1:0];
            whole   = avg_fix >> AVG_FRAC;
            vol_now = VOL_W'((whole * VOLUME_TOP) / KNOB_FULL);
        end
        // read-and-clear happens after this step's update, so a fresh press is seen
        if (req.take_press) begin
            res.press_seen = press_flag;
            press_flag     = 1'b0;
        end
        res.stable_button = stable_level;
        res.volume        = vol_now;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    logic        s_fire     = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // Sample the request handshake and predict at the rising edge.
    always @(posedge aclk) begin : take_requests
        if (s_valid && s_ready)
            results_due.push_back(debounce_and_smooth(s_item));
        s_fire <= s_valid && s_ready;
    end

    // Drive the next request at the falling edge; hold the current one until accepted.
    always @(negedge aclk) begin : drive_requests
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (poll_steps.size() != 0) begin
                s_item  <= poll_steps.pop_front();
                s_valid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    // end of burst: pick the next burst, and sometimes run straight on
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern with periodic long hold-offs, and checking
    // ------------------------------------------------------------------
    ready_mode_e       ready_mode   = READY_ALWAYS;
    int unsigned       pattern_left = 0;
    logic [15:0]       pattern_tick = '0;
    int unsigned       hold_left    = 0;
    int unsigned       next_hold_at = HOLD_SPACING;

    always @(negedge aclk) begin : drive_result_ready
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (results_taken >= next_hold_at) begin
            // hold off long enough for the pipeline to fill and push back on requests
            hold_left    = HOLD_CYCLES - 1;
            next_hold_at = next_hold_at + HOLD_SPACING;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                ready_mode   = ready_mode_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 80);
            end else begin
                pattern_left--;
            end
            pattern_tick = pattern_tick + 1'b1;
            case (ready_mode)
                READY_ALWAYS:        m_ready <= 1'b1;
                READY_THREE_OF_FOUR: m_ready <= (pattern_tick[1:0] != 2'b00);
                READY_COIN:          m_ready <= 1'($urandom_range(0, 1));
                default:             m_ready <= (pattern_tick % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (m_valid && m_ready) begin
            results_taken++;
            if (results_due.size() == 0) begin
                $error("result with no request outstanding: %p", m_item);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (m_item.press_seen !== want.press_seen) begin
                    $error("press_seen: expected %0d, got %0d", want.press_seen,
                           m_item.press_seen);
                    mismatches++;
                end
                if (m_item.stable_button !== want.stable_button) begin
                    $error("stable_button: expected %0d, got %0d", want.stable_button,
                           m_item.stable_button);
                    mismatches++;
                end
                if (m_item.volume !== want.volume) begin
                    $error("volume: expected %0d, got %0d", want.volume, m_item.volume);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind completes for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] gen_ms    = '0;
    logic              gen_level = 1'b1;
    int                knob_pos  = 2048;

    task automatic queue_step(input logic [TIME_W-1:0] at, input logic level,
                              input logic [KNOB_W-1:0] knob, input logic take);
        in_item_t req;
        req.now_ms       = at;
        req.button_level = level;
        req.knob_sample  = knob;
        req.take_press   = take;
        poll_steps.push_back(req);
    endtask

    // Random walk of the knob, with an occasional jump to an end stop.
    function automatic logic [KNOB_W-1:0] next_knob();
        if ($urandom_range(0, 9) == 0) begin
            knob_pos = ($urandom_range(0, 1) == 0) ? 0 : KNOB_FULL;
        end else begin
            knob_pos = knob_pos + int'($urandom_range(0, 400)) - 200;
            if (knob_pos < 0)
                knob_pos = 0;
            if (knob_pos > KNOB_FULL)
                knob_pos = KNOB_FULL;
        end
        return KNOB_W'(knob_pos);
    endfunction

    function automatic logic take_roll();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // Mostly press/release episodes (bounce, then a hold sized around the quiet time),
    // the rest noise: random levels, time jumps anywhere, repeated timestamps.
    task automatic random_polls(input int unsigned count);
        int unsigned made;
        int unsigned span;
        int unsigned piece;
        int unsigned hold_n;
        int unsigned bounce_n;
        int unsigned k;
        logic        target;
        made = 0;
        span = quiet_ms + 2;
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gen_ms = $urandom;
                    1:       gen_ms = gen_ms + $urandom_range(0, 3 * span);
                    default: gen_ms = gen_ms;
                endcase
                gen_level = 1'($urandom_range(0, 1));
                queue_step(gen_ms, gen_level, KNOB_W'($urandom_range(0, KNOB_FULL)),
                           1'($urandom_range(0, 1)));
                made++;
            end else begin
                target   = ~gen_level;
                bounce_n = $urandom_range(0, 4);
                for (k = 0; k < bounce_n; k++) begin
                    gen_ms = gen_ms + $urandom_range(0, span / 8 + 1);
                    queue_step(gen_ms, k[0] ? gen_level : target, next_knob(), take_roll());
                end
                // spread the hold so its total lands near the quiet time, either side
                hold_n = $urandom_range(2, 6);
                piece  = span / (hold_n - 1);
                for (k = 0; k < hold_n; k++) begin
                    if (k == 0)
                        gen_ms = gen_ms + $urandom_range(0, 2);
                    else
                        gen_ms = gen_ms + $urandom_range(piece / 2, piece + piece / 2 + 1);
                    queue_step(gen_ms, target, next_knob(), take_roll());
                end
                gen_level = target;
                made      = made + bounce_n + hold_n;
            end
        end
    endtask

    // Wait until every request has gone in and every result has come back, then settle.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (poll_steps.size() != 0 || s_valid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write (setup, access), then read back the same register.
    task automatic program_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'h0000, value}) begin
            $error("prdata: expected %0h, got %0h", {16'h0000, value}, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DEBOUNCE_QUIET: quiet_ms    = value;
            default:            interval_ms = value;
        endcase
    endtask

    logic [CFG_W-1:0] quiet_plan    [4];
    logic [CFG_W-1:0] interval_plan [4];

    initial begin : run_sequence
        int p;
        // extremes, a short random setting, and the two extremes crossed
        quiet_plan[0] = '0;          interval_plan[0] = '0;
        quiet_plan[1] = 16'hFFFF;    interval_plan[1] = 16'hFFFF;
        quiet_plan[2] = CFG_W'($urandom_range(1, 60));
        interval_plan[2] = CFG_W'($urandom_range(1, 60));
        quiet_plan[3] = 16'hFFFF;    interval_plan[3] = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed steps at the reset settings (quiet 50, interval 20).
        queue_step(32'd0,   1'b1, 12'd0,    1'b1);  // no sample yet: volume 0, nothing to take
        queue_step(32'd19,  1'b1, 12'hFFF,  1'b0);  // one short of the interval
        queue_step(32'd20,  1'b1, 12'hFFF,  1'b0);  // first sample loads the average
        queue_step(32'd21,  1'b1, 12'd0,    1'b0);  // too soon for another sample
        queue_step(32'd40,  1'b1, 12'd0,    1'b0);  // decay toward zero
        queue_step(32'd45,  1'b0, 12'd0,    1'b0);  // raw press, timer restarts
        queue_step(32'd95,  1'b0, 12'd2048, 1'b1);  // exactly the quiet time: not yet
        queue_step(32'd96,  1'b0, 12'd2048, 1'b1);  // accepted, press seen in the same step
        queue_step(32'd97,  1'b0, 12'd2048, 1'b1);  // flag already cleared
        queue_step(32'd100, 1'b1, 12'd1000, 1'b0);  // release with contact bounce
        queue_step(32'd101, 1'b0, 12'd1000, 1'b0);
        queue_step(32'd102, 1'b1, 12'd1000, 1'b0);
        queue_step(32'd200, 1'b1, 12'd1000, 1'b0);  // release accepted
        queue_step(32'd210, 1'b0, 12'd3000, 1'b0);
        queue_step(32'd300, 1'b0, 12'd3000, 1'b0);  // press latched, not taken
        queue_step(32'd301, 1'b0, 12'd3000, 1'b0);
        queue_step(32'd302, 1'b0, 12'd3000, 1'b1);  // taken later
        queue_step(32'hFFFF_FFF0, 1'b1, 12'hFFF, 1'b0);  // far jump near the top of time
        queue_step(32'hFFFF_FFFF, 1'b1, 12'hAAA, 1'b1);
        queue_step(32'h0000_0030, 1'b1, 12'h555, 1'b0);  // time wraps through zero
        queue_step(32'h0000_0030, 1'b0, 12'd0,   1'b0);  // same timestamp twice
        queue_step(32'h7FFF_FFFF, 1'b0, 12'hFFF, 1'b1);  // half-range jump
        gen_ms    = 32'h7FFF_FFFF;
        gen_level = 1'b0;

        random_polls(PHASE_POLLS);
        for (p = 0; p < 4; p++) begin
            // reprogram only with nothing in flight
            wait_drained();
            program_register(REG_DEBOUNCE_QUIET, quiet_plan[p]);
            program_register(REG_KNOB_INTERVAL, interval_plan[p]);
            random_polls(PHASE_POLLS);
        end

        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
